/* sv/gcpl_pkg.sv */
// Package for the great-circle path length block: CORDIC constants, arctangent
// table, shared widths and state machine type. No dependencies.
`default_nettype none
package gcpl_pkg;
   localparam int CORDIC_ITERATIONS = 30;
   localparam int TABLE_LEN = 40;
   localparam int ITER_COUNT = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
   localparam int ITER_W = $clog2(TABLE_LEN);

   // working width of the CORDIC datapath (Q2.30 plus guard)
   localparam int DW = 36;

   localparam logic signed [DW-1:0] Q30_ONE = DW'(64'sd1 << 30);
   localparam logic signed [DW-1:0] CORDIC_GAIN = DW'(64'sd652032874);
   localparam logic [24:0] RADK = 25'd18740326;
   localparam logic signed [26:0] DEG90 = 27'sd5898240;
   localparam logic signed [26:0] DEG180 = 27'sd11796480;
   localparam logic signed [26:0] DEG360 = 27'sd23592960;
   localparam logic [24:0] LEG_MUL = 25'd16329728;

   function automatic logic signed [DW-1:0] atan_entry(input logic [ITER_W-1:0] i);
      logic signed [DW-1:0] v;
      case (i)
         6'd0: v = DW'(36'sh3243F6A8);
         6'd1: v = DW'(36'sh1DAC6705);
         6'd2: v = DW'(36'sh0FADBAFC);
         6'd3: v = DW'(36'sh07F56EA6);
         6'd4: v = DW'(36'sh03FEAB76);
         6'd5: v = DW'(36'sh01FFD55B);
         6'd6: v = DW'(36'sh00FFFAAA);
         6'd7: v = DW'(36'sh007FFF55);
         6'd8: v = DW'(36'sh003FFFEA);
         6'd9: v = DW'(36'sh001FFFFD);
         6'd10: v = DW'(36'sh000FFFFF);
         6'd11: v = DW'(36'sh0007FFFF);
         6'd12: v = DW'(36'sh0003FFFF);
         6'd13: v = DW'(36'sh0001FFFF);
         6'd14: v = DW'(36'sh0000FFFF);
         6'd15: v = DW'(36'sh00007FFF);
         6'd16: v = DW'(36'sh00003FFF);
         6'd17: v = DW'(36'sh00001FFF);
         6'd18: v = DW'(36'sh00000FFF);
         6'd19: v = DW'(36'sh000007FF);
         6'd20: v = DW'(36'sh000003FF);
         6'd21: v = DW'(36'sh000001FF);
         6'd22: v = DW'(36'sh000000FF);
         6'd23: v = DW'(36'sh0000007F);
         6'd24: v = DW'(36'sh0000003F);
         6'd25: v = DW'(36'sh0000001F);
         6'd26: v = DW'(36'sh0000000F);
         6'd27: v = DW'(36'sh00000008);
         6'd28: v = DW'(36'sh00000004);
         6'd29: v = DW'(36'sh00000002);
         6'd30: v = DW'(36'sh00000001);
         default: v = '0;
      endcase
      return v;
   endfunction

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE, ST_RAD, ST_ROT, ST_PROD, ST_SQRT, ST_ACOS, ST_LEG, ST_DONE
   } state_type;

   // multiply-unit operation selectors
   typedef enum logic [1:0] {
      MOP_Q30, MOP_RAD, MOP_LEG
   } mop_type;
endpackage
`default_nettype wire

/* sv/gcpl_mul.sv */
// Shift-add multiplier for the great-circle block: one 2-bit digit of the
// multiplier per cycle, magnitudes only. Uses gcpl_pkg.
`default_nettype none
module gcpl_mul
   import gcpl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [35:0]  a_mag,
   input  wire logic [35:0]  b_mag,
   output logic              busy,
   output logic [71:0]       product
);
   logic [71:0] acc_ff, acc_in;
   logic [71:0] mcand_ff, mcand_in;
   logic [35:0] mplier_ff, mplier_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   // one radix-4 digit per cycle
   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in = '0;
         mcand_in = {36'd0, a_mag};
         mplier_in = b_mag;
         cnt_in = 5'd18;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (mplier_ff[0] ? mcand_ff : 72'd0)
                  + (mplier_ff[1] ? {mcand_ff[70:0], 1'b0} : 72'd0);
         mcand_in = {mcand_ff[69:0], 2'b00};
         mplier_in = {2'b00, mplier_ff[35:2]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy = busy_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

/* sv/great_circle_path_length.sv */
// Top level of the great-circle path length block: sequencer, CORDIC,
// square root and route total. Uses gcpl_pkg and gcpl_mul.
//
// channel | dir | ports                  | content
// req     | in  | req_tvalid/tready/tdata/tuser | latitude, longitude; tuser route_start
// rsp     | out | rsp_tvalid/tready/tdata       | leg_length, route_total, total_saturated
//
// A leg point runs from accept to the next accept through three radian
// conversions and 30-step rotations, three products, squaring the cosine plus a
// 31-step square root, a vectoring pass and the leg scaling multiply, then the
// done state, the response and idle. Every multiply runs on the shared
// 2-bit-per-cycle multiplier. First points and route starts go straight to
// done. Reset clears the route state. The result sits in an output register;
// the next point is taken once it has been read.
`default_nettype none
module great_circle_path_length
   import gcpl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // [23:0] latitude, [48:24] longitude
   input  wire logic        req_tuser,  // route_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata   // [22:0] leg_length, [54:23] route_total,
                                        // [55] total_saturated
);
   state_type state_ff, state_in;

   logic signed [23:0] prev_lat_ff;
   logic signed [24:0] prev_lon_ff;
   logic               have_prev_ff;
   logic [31:0]        total_ff;
   logic               sat_ff;
   logic [22:0]        leg_ff;
   logic               rsp_valid_ff;
   logic signed [23:0] lat_ff;
   logic signed [24:0] lon_ff;

   // angle job: 0 = lat1, 1 = lat2, 2 = dlon
   logic [1:0]  job_ff;
   logic        neg_ff;
   logic [2:0]  sub_ff;      // micro-step within a state
   logic [5:0]  it_ff;
   logic signed [DW-1:0] x_ff, y_ff, z_ff;
   logic signed [DW-1:0] c1_ff, s1_ff, c2_ff, s2_ff, cd_ff, t_ff, arg_ff;
   logic signed [26:0]   deg_ff;
   // square root
   logic [61:0] rem_ff;
   logic [30:0] root_ff;

   // multiplier
   logic        m_start;
   logic [35:0] m_a, m_b;
   logic        m_busy;
   logic [71:0] m_p;
   logic        m_neg_ff;

   gcpl_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (m_start),
      .a_mag  (m_a),
      .b_mag  (m_b),
      .busy   (m_busy),
      .product(m_p)
   );

   function automatic logic [35:0] mag(input logic signed [DW-1:0] v);
      return v[DW-1] ? 36'(-v) : 36'(v);
   endfunction

   function automatic logic signed [26:0] clamp_lat(input logic signed [23:0] v);
      logic signed [26:0] e;
      e = 27'(v);
      if (e > DEG90) return DEG90;
      if (e < -DEG90) return -DEG90;
      return e;
   endfunction

   // signed Q30 product with round-half-up and floor of the signed value
   logic signed [72:0] sprod;
   logic signed [DW-1:0] q30_res;
   always_comb begin
      sprod = m_neg_ff ? -$signed({1'b0, m_p}) : $signed({1'b0, m_p});
      q30_res = DW'((sprod + 73'sd536870912) >>> 30);
   end

   // CORDIC shifted operands
   logic signed [DW-1:0] xs, ys, atn;
   logic                 dir_pos;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign atn = atan_entry(it_ff);

   // longitude difference folded into 0..90 degrees
   logic signed [26:0] dd;
   logic               dneg;
   always_comb begin
      dd = 27'(lon_ff) - 27'(prev_lon_ff);
      if (dd >= DEG360) dd = dd - DEG360;
      if (dd < 0) dd = dd + DEG360;
      if (dd < 0) dd = dd + DEG360;
      if (dd > DEG180) dd = DEG360 - dd;
      dneg = dd > DEG90;
      if (dneg) dd = DEG180 - dd;
   end

   // square-root step (restoring, one root bit per cycle)
   logic [62:0] trial;
   assign trial = {1'b0, rem_ff} - 63'({root_ff, 2'b01} << (2 * (30 - it_ff)));

   logic [31:0] sum_hi;
   logic [32:0] sum;
   assign sum = {1'b0, total_ff} + {10'd0, leg_ff};
   assign sum_hi = sum[32] ? 32'hFFFFFFFF : sum[31:0];

   logic [22:0] leg_in_c;
   logic        fire;
   assign fire = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      m_start = 1'b0;
      m_a = '0;
      m_b = '0;
      dir_pos = 1'b0;
      leg_in_c = 23'(m_p[71:32] + 40'd0);
      unique case (state_ff)
         ST_IDLE: if (fire) begin
            if (req_tuser || !have_prev_ff) state_in = ST_DONE;
            else state_in = ST_RAD;
         end
         ST_RAD: begin
            if (sub_ff == 3'd0) begin
               m_start = 1'b1;
               m_a = 36'(deg_ff[26] ? -deg_ff : deg_ff);
               m_b = 36'(RADK);
            end
            if (sub_ff == 3'd2 && !m_busy) state_in = ST_ROT;
         end
         ST_ROT: begin
            dir_pos = !z_ff[DW-1];
            if (it_ff == 6'(ITER_COUNT - 1)) begin
               if (job_ff == 2'd2) state_in = ST_PROD;
               else state_in = ST_RAD;
            end
         end
         ST_PROD: begin
            // three products in sequence
            if (!m_busy && sub_ff[0] == 1'b0) begin
               m_start = 1'b1;
               unique case (sub_ff)
                  3'd0: begin m_a = mag(s1_ff); m_b = mag(s2_ff); end
                  3'd2: begin m_a = mag(c1_ff); m_b = mag(c2_ff); end
                  3'd4: begin m_a = mag(t_ff); m_b = mag(cd_ff); end
                  default: m_start = 1'b0;
               endcase
            end
            if (sub_ff == 3'd6) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // square the clamped cosine on the shared multiplier
            if (sub_ff == 3'd0) begin
               m_start = 1'b1;
               m_a = mag(arg_ff);
               m_b = mag(arg_ff);
            end
            if (it_ff == 6'd30) state_in = ST_ACOS;
         end
         ST_ACOS: begin
            dir_pos = y_ff > 0;
            if (sub_ff == 3'd1 && it_ff == 6'(ITER_COUNT - 1)) state_in = ST_LEG;
         end
         ST_LEG: begin
            if (sub_ff == 3'd0) begin
               m_start = 1'b1;
               m_a = z_ff[DW-1] ? 36'd0 : 36'(z_ff);
               m_b = 36'(LEG_MUL);
            end
            if (sub_ff == 3'd2 && !m_busy) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // leg = round(ang*LEG_MUL / (10*2^30)); the 2^30 part is a shift and the
   // divide by 10 a reciprocal multiply, exact for numerators below 2^32
   logic [29:0] leg_num;
   logic [22:0] leg_q;
   always_comb begin
      logic [61:0] recip;
      leg_num = 30'((m_p + 72'd5368709120) >> 30);
      recip = 62'(leg_num) * 62'd3435973837;
      leg_q = 23'(recip >> 35);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_prev_ff <= 1'b0;
         total_ff <= '0;
         sat_ff <= 1'b0;
         prev_lat_ff <= '0;
         prev_lon_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sub_ff <= '0;
         it_ff <= '0;
         job_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (fire) begin
               lat_ff <= $signed(req_tdata[23:0]);
               lon_ff <= $signed(req_tdata[48:24]);
               leg_ff <= '0;
               if (req_tuser) begin
                  total_ff <= '0;
                  sat_ff <= 1'b0;
               end
               job_ff <= 2'd0;
               sub_ff <= '0;
               deg_ff <= clamp_lat(prev_lat_ff);
            end
            ST_RAD: begin
               if (sub_ff != 3'd2) sub_ff <= sub_ff + 3'd1;
               if (sub_ff == 3'd2 && !m_busy) begin
                  // to radians, sign applied after rounding
                  x_ff <= CORDIC_GAIN;
                  y_ff <= '0;
                  z_ff <= deg_ff[26] ? -DW'((m_p + 72'd32768) >> 16)
                                     : DW'((m_p + 72'd32768) >> 16);
                  it_ff <= '0;
                  sub_ff <= '0;
               end
            end
            ST_ROT: begin
               x_ff <= dir_pos ? x_ff - ys : x_ff + ys;
               y_ff <= dir_pos ? y_ff + xs : y_ff - xs;
               z_ff <= dir_pos ? z_ff - atn : z_ff + atn;
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'(ITER_COUNT - 1)) begin
                  it_ff <= '0;
                  job_ff <= job_ff + 2'd1;
                  unique case (job_ff)
                     2'd0: begin
                        c1_ff <= dir_pos ? x_ff - ys : x_ff + ys;
                        s1_ff <= dir_pos ? y_ff + xs : y_ff - xs;
                        deg_ff <= clamp_lat(lat_ff);
                     end
                     2'd1: begin
                        c2_ff <= dir_pos ? x_ff - ys : x_ff + ys;
                        s2_ff <= dir_pos ? y_ff + xs : y_ff - xs;
                        deg_ff <= dd;
                        neg_ff <= dneg;
                     end
                     default: begin
                        cd_ff <= neg_ff ? -(dir_pos ? x_ff - ys : x_ff + ys)
                                        : (dir_pos ? x_ff - ys : x_ff + ys);
                     end
                  endcase
               end
            end
            ST_PROD: begin
               if (m_start) begin
                  sub_ff <= sub_ff + 3'd1;
                  unique case (sub_ff)
                     3'd0: m_neg_ff <= s1_ff[DW-1] ^ s2_ff[DW-1];
                     3'd2: m_neg_ff <= c1_ff[DW-1] ^ c2_ff[DW-1];
                     default: m_neg_ff <= t_ff[DW-1] ^ cd_ff[DW-1];
                  endcase
               end else if (!m_busy && sub_ff[0]) begin
                  sub_ff <= sub_ff + 3'd1;
                  unique case (sub_ff)
                     3'd1: arg_ff <= q30_res;
                     3'd3: t_ff <= q30_res;
                     default: begin
                        // sum and clamp to [-1, 1]
                        if (arg_ff + q30_res > Q30_ONE) arg_ff <= Q30_ONE;
                        else if (arg_ff + q30_res < -Q30_ONE) arg_ff <= -Q30_ONE;
                        else arg_ff <= arg_ff + q30_res;
                     end
                  endcase
               end
               if (sub_ff == 3'd6) begin
                  sub_ff <= '0;
                  it_ff <= '0;
                  root_ff <= '0;
                  // a^2 comes from the multiplier at the square-root start
                  rem_ff <= '0;
               end
            end
            ST_SQRT: begin
               if (sub_ff == 3'd0) begin
                  sub_ff <= 3'd1;
               end else if (sub_ff == 3'd1) begin
                  if (!m_busy) begin
                     rem_ff <= 62'((64'd1 << 60) - m_p[63:0]);
                     sub_ff <= 3'd2;
                  end
               end else begin
                  if (!trial[62]) begin
                     rem_ff <= trial[61:0];
                     root_ff <= {root_ff[29:0], 1'b1};
                  end else begin
                     root_ff <= {root_ff[29:0], 1'b0};
                  end
                  it_ff <= it_ff + 6'd1;
                  if (it_ff == 6'd30) begin
                     it_ff <= '0;
                     sub_ff <= '0;
                  end
               end
            end
            ST_ACOS: begin
               if (sub_ff == 3'd0) begin
                  if (!arg_ff[DW-1]) begin
                     x_ff <= arg_ff;
                     y_ff <= DW'(root_ff);
                     z_ff <= '0;
                  end else begin
                     x_ff <= DW'(root_ff);
                     y_ff <= -arg_ff;
                     z_ff <= DW'(atan_entry('0)) <<< 1;
                  end
                  it_ff <= '0;
                  sub_ff <= 3'd1;
               end else begin
                  x_ff <= dir_pos ? x_ff + ys : x_ff - ys;
                  y_ff <= dir_pos ? y_ff - xs : y_ff + xs;
                  z_ff <= dir_pos ? z_ff + atn : z_ff - atn;
                  it_ff <= it_ff + 6'd1;
                  if (it_ff == 6'(ITER_COUNT - 1)) sub_ff <= '0;
               end
            end
            ST_LEG: begin
               if (sub_ff != 3'd2) sub_ff <= sub_ff + 3'd1;
               if (sub_ff == 3'd2 && !m_busy) begin
                  leg_ff <= leg_q;
                  sub_ff <= '0;
               end
            end
            ST_DONE: begin
               prev_lat_ff <= lat_ff;
               prev_lon_ff <= lon_ff;
               have_prev_ff <= 1'b1;
               rsp_valid_ff <= 1'b1;
               if (!sat_ff || leg_ff == 23'd0) begin
                  total_ff <= sum_hi;
                  if (sum[32]) sat_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {sat_ff, total_ff, leg_ff};

   logic unused_ok;
   assign unused_ok = ^{leg_in_c, req_tdata[55:49]};
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for great_circle_path_length: streams route points, predicts legs
// and running totals with its own CORDIC model and checks every result.
// Depends on gcpl_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
   import gcpl_pkg::*;

   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint RAD_PER_DEG = 64'sd18740326;
   localparam longint LAT_MAX = 64'sd5898240;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint FULL_TURN = 64'sd23592960;
   localparam longint KM256_PER_RAD = 64'sd16329728;
   localparam longint TOTAL_MAX = 64'sd4294967295;
   localparam int CYCLE_LIMIT = 6000000;

   // atan(2^-i) * 2^30, as integers
   localparam longint ARCTAN_Q30 [0:TABLE_LEN-1] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   typedef struct packed {
      logic signed [23:0] latitude;
      logic signed [24:0] longitude;
      logic               route_start;
   } route_point_t;

   typedef struct packed {
      logic [22:0] leg_length;
      logic [31:0] route_total;
      logic        total_saturated;
   } route_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // [23:0] latitude, [48:24] longitude
   logic        req_tuser;   // route_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [22:0] leg_length, [54:23] route_total, [55] total_saturated

   great_circle_path_length u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   route_point_t  point_queue[$];
   route_result_t expected_results[$];
   route_point_t  point_in_flight;
   int            error_count;
   int            cycle_count;
   int            send_gap;
   int            ready_gap;
   int            legs_checked;
   int            starts_sent;
   int            saturated_seen;

   // route state of the predictor
   longint last_lat;
   longint last_lon;
   bit     seen_point;
   longint total_km256;
   bit     total_stuck;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint deg_to_rad(longint d);
      longint m;
      longint r;
      m = (d < 0) ? -d : d;
      r = (m * RAD_PER_DEG + 32768) >>> 16;
      return (d < 0) ? -r : r;
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic void rotate(longint angle, output longint c, output longint s);
      longint x;
      longint y;
      longint nx;
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < ITER_COUNT; i++) begin
         if (angle >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); angle -= ARCTAN_Q30[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); angle += ARCTAN_Q30[i];
         end
         x = nx;
      end
      c = x;
      s = y;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint arc_cosine(longint a);
      longint x;
      longint y;
      longint z;
      longint nx;
      longint r;
      r = int_sqrt(longint'(ONE_Q30 * ONE_Q30 - a * a));
      if (a >= 0) begin
         x = a; y = r; z = 0;
      end else begin
         x = r; y = -a; z = 2 * ARCTAN_Q30[0];
      end
      for (int i = 0; i < ITER_COUNT; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN_Q30[i];
         end else begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN_Q30[i];
         end
         x = nx;
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint clip_lat(longint v);
      if (v > LAT_MAX) return LAT_MAX;
      if (v < -LAT_MAX) return -LAT_MAX;
      return v;
   endfunction

   function automatic longint leg_km256(longint lat1, longint lon1, longint lat2,
                                        longint lon2);
      longint c1, s1, c2, s2, cd, sd, d, cos_arc, ang;
      bit     far_side;
      far_side = 0;
      rotate(deg_to_rad(clip_lat(lat1)), c1, s1);
      rotate(deg_to_rad(clip_lat(lat2)), c2, s2);
      // fold the longitude difference into 0..90 degrees
      d = (lon2 - lon1) % FULL_TURN;
      if (d < 0) d += FULL_TURN;
      if (d > HALF_TURN) d = FULL_TURN - d;
      if (d > LAT_MAX) begin
         far_side = 1;
         d = HALF_TURN - d;
      end
      rotate(deg_to_rad(d), cd, sd);
      if (far_side) cd = -cd;
      cos_arc = mul_q30(s1, s2) + mul_q30(mul_q30(c1, c2), cd);
      if (cos_arc > ONE_Q30) cos_arc = ONE_Q30;
      if (cos_arc < -ONE_Q30) cos_arc = -ONE_Q30;
      ang = arc_cosine(cos_arc);
      return ((ang * KM256_PER_RAD + (64'sd5 << 30)) / (64'sd10 << 30)) & 64'h7FFFFF;
   endfunction

   function automatic route_result_t advance_route(route_point_t p);
      route_result_t res;
      longint        leg;
      longint        lat;
      longint        lon;
      lat = p.latitude;
      lon = p.longitude;
      leg = 0;
      if (p.route_start) begin
         total_km256 = 0;
         total_stuck = 0;
      end else if (seen_point) begin
         leg = leg_km256(last_lat, last_lon, lat, lon);
         if (total_km256 + leg > TOTAL_MAX) begin
            total_km256 = TOTAL_MAX;
            total_stuck = 1;
         end else begin
            total_km256 += leg;
         end
      end
      last_lat = lat;
      last_lon = lon;
      seen_point = 1;
      res.leg_length = leg[22:0];
      res.route_total = total_km256[31:0];
      res.total_saturated = total_stuck;
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic add_point(longint lat, longint lon, bit start);
      route_point_t p;
      p.latitude = lat[23:0];
      p.longitude = lon[24:0];
      p.route_start = start;
      point_queue = {point_queue, p};
   endtask

   function automatic longint random_lat();
      if ($urandom_range(0, 3) == 0) return longint'($signed(24'($urandom)));
      return longint'($urandom_range(0, 2 * 5898240)) - LAT_MAX;
   endfunction

   function automatic longint random_lon();
      if ($urandom_range(0, 3) == 0) return longint'($signed(25'($urandom)));
      return longint'($urandom_range(0, 2 * 11796480)) - HALF_TURN;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      route_point_t next_point;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results = {expected_results, advance_route(point_in_flight)};
            if (point_in_flight.route_start) starts_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (point_queue.size() > 0) begin
               next_point = point_queue.pop_front();
               point_in_flight <= next_point;
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, next_point.longitude, next_point.latitude};
               req_tuser <= next_point.route_start;
               if (point_queue.size() > 50 && $urandom_range(0, 3) == 0)
                  send_gap <= $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      route_result_t got;
      route_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.leg_length = rsp_tdata[22:0];
            got.route_total = rsp_tdata[54:23];
            got.total_saturated = rsp_tdata[55];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transaction", longint'(rsp_tdata), 0);
            end else begin
               want = expected_results.pop_front();
               if (got.leg_length != want.leg_length)
                  report_mismatch("leg_length", got.leg_length, want.leg_length);
               if (got.route_total != want.route_total)
                  report_mismatch("route_total", got.route_total, want.route_total);
               if (got.total_saturated != want.total_saturated)
                  report_mismatch("total_saturated", got.total_saturated,
                                  want.total_saturated);
               if (want.leg_length != 0) legs_checked++;
               if (want.total_saturated) saturated_seen++;
            end
         end
         // ready stalls in bursts, none near the end
         if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            rsp_tready <= 1'b0;
         end else if (point_queue.size() > 50 && $urandom_range(0, 4) == 0) begin
            ready_gap <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      longint lat;
      longint lon;
      error_count = 0;
      cycle_count = 0;
      legs_checked = 0;
      starts_sent = 0;
      saturated_seen = 0;
      last_lat = 0;
      last_lon = 0;
      seen_point = 0;
      total_km256 = 0;
      total_stuck = 0;
      point_in_flight = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;

      // directed: first point after reset without start, then edge cases
      add_point(65536, 65536, 0);
      add_point(65536, 65536, 0);                 // same point, zero leg
      add_point(0, 0, 1);
      add_point(0, HALF_TURN, 0);                 // antipodal on the equator
      add_point(LAT_MAX, 0, 0);                   // pole
      add_point(-LAT_MAX, 0, 0);                  // pole to pole
      add_point(-8388608, -16777216, 0);          // most negative field values
      add_point(8388607, 16777215, 0);            // most positive field values
      add_point(0, -HALF_TURN, 0);
      add_point(0, 3 * LAT_MAX, 0);               // longitude beyond range
      add_point(2949120, 100, 0);
      add_point(-2949120, 100 + HALF_TURN, 0);    // near antipodal
      add_point(0, 0, 1);
      add_point(0, LAT_MAX, 0);                   // quarter turn
      add_point(0, LAT_MAX + 1, 0);
      add_point(1, LAT_MAX + 2, 0);
      add_point(0, -FULL_TURN + 5, 0);
      add_point(-1, 0, 1);
      add_point(0, 1, 0);                         // tiny leg

      // long route of near-antipodal legs building up a large total
      add_point(0, 0, 1);
      for (int i = 0; i < 300; i++) begin
         lat = longint'($urandom_range(0, 200)) - 100;
         lon = ((i % 2) == 0) ? HALF_TURN : 0;
         add_point(lat, lon + longint'($urandom_range(0, 200)) - 100, 0);
      end

      // random routes, mostly well formed with occasional restarts
      for (int i = 0; i < 280; i++) begin
         lat = random_lat();
         lon = random_lon();
         add_point(lat, lon, $urandom_range(0, 15) == 0);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (point_queue.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (20) @(posedge clock);

      $display("Checked %0d nonzero legs over %0d route starts; %0d results saturated.",
               legs_checked, starts_sent, saturated_seen);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
